// ===== hw/rtl/e131pc_pkg.sv =====
// ----------------------------------------------------------------------------
// e131pc_pkg
// Shared types and constants for the E1.31 packet classifier.
// ----------------------------------------------------------------------------
package e131pc_pkg;

	localparam int MAX_PACKET_BYTES_DEF = 638;
	localparam int OFFSET_W             = 11;
	localparam int Q_DEPTH              = 4;
	localparam int Q_PTR_W              = $clog2(Q_DEPTH);
	localparam int Q_CNT_W              = $clog2(Q_DEPTH + 1);

	localparam logic [31:0] ROOT_DATA        = 32'h0000_0004;
	localparam logic [31:0] ROOT_EXTENDED    = 32'h0000_0008;
	localparam logic [31:0] FRAME_DATA       = 32'h0000_0002;
	localparam logic [31:0] FRAME_SYNC       = 32'h0000_0001;
	localparam logic [31:0] FRAME_DISCOVERY  = 32'h0000_0002;
	localparam logic [7:0]  DMP_SET_PROPERTY = 8'h02;
	localparam logic [31:0] DISCOVERY_LIST   = 32'h0000_0001;
	localparam logic [7:0]  DMP_ADDR_TYPE    = 8'hA1;
	localparam logic [7:0]  DMP_ADDR_INC     = 8'h01;
	localparam logic [15:0] PROP_COUNT_MAX   = 16'd513;
	localparam logic [11:0] MIN_LEN_ANY      = 12'd48;
	localparam logic [11:0] MIN_LEN_DATA     = 12'd125;
	localparam logic [11:0] MIN_LEN_DISC     = 12'd119;

	typedef enum logic [1:0] {
		KIND_INVALID   = 2'd0,
		KIND_DATA      = 2'd1,
		KIND_SYNC      = 2'd2,
		KIND_DISCOVERY = 2'd3
	} kind_t;

	typedef struct packed {
		logic        slot_valid;
		logic [8:0]  slot_number;
		logic [7:0]  slot_data;
		logic [15:0] target_universe;
		logic        verdict_valid;
		kind_t       kind;
		logic        bcast;
		logic [15:0] sync_universe;
	} result_t;

	// Preamble sizes and ACN packet identifier
	function automatic logic [7:0] head_byte(input logic [3:0] idx);
		logic [7:0] v;
		case (idx)
			4'd1:    v = 8'h10;
			4'd4:    v = 8'h41;
			4'd5:    v = 8'h53;
			4'd6:    v = 8'h43;
			4'd7:    v = 8'h2D;
			4'd8:    v = 8'h45;
			4'd9:    v = 8'h31;
			4'd10:   v = 8'h2E;
			4'd11:   v = 8'h31;
			4'd12:   v = 8'h37;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/e131pc_front.sv =====
// ----------------------------------------------------------------------------
// e131pc_front
// Byte parser: header checks, field capture and packet classification.
// ----------------------------------------------------------------------------
module e131pc_front #(
	parameter int MAX_PACKET_BYTES = e131pc_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [7:0]            payload_byte,
	input  logic                  end_of_packet,
	input  logic                  via_broadcast,
	output logic                  push,
	output e131pc_pkg::result_t   push_data
);

	localparam logic [e131pc_pkg::OFFSET_W-1:0] OFF_LIMIT =
		e131pc_pkg::OFFSET_W'(MAX_PACKET_BYTES);
	localparam logic [e131pc_pkg::OFFSET_W-1:0] OFF_MAX = '1;

	logic [e131pc_pkg::OFFSET_W-1:0] off_q;
	logic        fault_q;
	logic [31:0] root_q, frame_q, layer_q;
	logic [15:0] univ_q, psync_q, pcount_q;

	logic        fault_n;
	logic [31:0] root_n, frame_n, layer_n;
	logic [15:0] univ_n, psync_n, pcount_n;
	logic        is_data, is_sync, is_disc;
	logic        slot;
	logic [16:0] slot_hi;
	logic [11:0] len;
	e131pc_pkg::kind_t kind;

	always_comb begin
		root_n   = root_q;
		frame_n  = frame_q;
		layer_n  = layer_q;
		univ_n   = univ_q;
		psync_n  = psync_q;
		pcount_n = pcount_q;
		fault_n  = fault_q;

		if (off_q < 11'd16) begin
			if (payload_byte != e131pc_pkg::head_byte(off_q[3:0]))
				fault_n = 1'b1;
		end else if (off_q >= 11'd18 && off_q <= 11'd21) begin
			root_n = {root_q[23:0], payload_byte};
			if (off_q == 11'd21 && root_n != e131pc_pkg::ROOT_DATA &&
			    root_n != e131pc_pkg::ROOT_EXTENDED)
				fault_n = 1'b1;
		end else if (off_q >= 11'd40 && off_q <= 11'd43) begin
			frame_n = {frame_q[23:0], payload_byte};
			if (off_q == 11'd43) begin
				if (root_n == e131pc_pkg::ROOT_DATA && frame_n != e131pc_pkg::FRAME_DATA)
					fault_n = 1'b1;
				if (root_n == e131pc_pkg::ROOT_EXTENDED &&
				    frame_n != e131pc_pkg::FRAME_SYNC &&
				    frame_n != e131pc_pkg::FRAME_DISCOVERY)
					fault_n = 1'b1;
			end
		end

		is_data = root_n == e131pc_pkg::ROOT_DATA && frame_n == e131pc_pkg::FRAME_DATA;
		is_sync = root_n == e131pc_pkg::ROOT_EXTENDED && frame_n == e131pc_pkg::FRAME_SYNC;
		is_disc = root_n == e131pc_pkg::ROOT_EXTENDED &&
			frame_n == e131pc_pkg::FRAME_DISCOVERY;

		if ((off_q == 11'd45 || off_q == 11'd46) && is_sync)
			psync_n = {psync_q[7:0], payload_byte};
		if ((off_q == 11'd109 || off_q == 11'd110) && is_data)
			psync_n = {psync_q[7:0], payload_byte};
		if ((off_q == 11'd113 || off_q == 11'd114) && is_data)
			univ_n = {univ_q[7:0], payload_byte};

		if (off_q >= 11'd114 && off_q <= 11'd117) begin
			layer_n = {layer_q[23:0], payload_byte};
			if (off_q == 11'd117) begin
				if (is_data && layer_n[7:0] != e131pc_pkg::DMP_SET_PROPERTY)
					fault_n = 1'b1;
				if (is_disc && layer_n != e131pc_pkg::DISCOVERY_LIST)
					fault_n = 1'b1;
			end
		end

		if (is_data) begin
			if (off_q == 11'd118 && payload_byte != e131pc_pkg::DMP_ADDR_TYPE)
				fault_n = 1'b1;
			if ((off_q == 11'd119 || off_q == 11'd120 || off_q == 11'd121) &&
			    payload_byte != 8'h00)
				fault_n = 1'b1;
			if (off_q == 11'd122 && payload_byte != e131pc_pkg::DMP_ADDR_INC)
				fault_n = 1'b1;
			if (off_q == 11'd123 || off_q == 11'd124) begin
				pcount_n = {pcount_q[7:0], payload_byte};
				if (off_q == 11'd124 &&
				    (pcount_n == 16'd0 || pcount_n > e131pc_pkg::PROP_COUNT_MAX))
					fault_n = 1'b1;
			end
		end

		if (off_q >= OFF_LIMIT)
			fault_n = 1'b1;

		slot_hi = 17'd124 + {1'b0, pcount_n};
		slot = is_data && !fault_n && off_q >= 11'd126 && {6'd0, off_q} <= slot_hi;

		len  = {1'b0, off_q} + 12'd1;
		kind = e131pc_pkg::KIND_INVALID;
		if (!fault_n && len >= e131pc_pkg::MIN_LEN_ANY) begin
			if (is_data && len >= e131pc_pkg::MIN_LEN_DATA)
				kind = e131pc_pkg::KIND_DATA;
			else if (is_sync)
				kind = e131pc_pkg::KIND_SYNC;
			else if (is_disc && len >= e131pc_pkg::MIN_LEN_DISC)
				kind = e131pc_pkg::KIND_DISCOVERY;
		end
		if (!end_of_packet)
			kind = e131pc_pkg::KIND_INVALID;
	end

	assign push = take && (slot || end_of_packet);

	always_comb begin
		push_data.slot_valid      = slot;
		push_data.slot_number     = slot ? 9'(off_q - 11'd126) : 9'd0;
		push_data.slot_data       = slot ? payload_byte : 8'd0;
		push_data.target_universe = univ_n;
		push_data.verdict_valid   = end_of_packet;
		push_data.kind            = kind;
		push_data.bcast           = via_broadcast;
		push_data.sync_universe   = psync_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= '0;
			fault_q  <= 1'b0;
			root_q   <= '0;
			frame_q  <= '0;
			layer_q  <= '0;
			univ_q   <= '0;
			psync_q  <= '0;
			pcount_q <= '0;
		end else if (take) begin
			if (end_of_packet) begin
				off_q    <= '0;
				fault_q  <= 1'b0;
				root_q   <= '0;
				frame_q  <= '0;
				layer_q  <= '0;
				univ_q   <= '0;
				psync_q  <= '0;
				pcount_q <= '0;
			end else begin
				if (off_q != OFF_MAX)
					off_q <= off_q + 1'b1;
				fault_q  <= fault_n;
				root_q   <= root_n;
				frame_q  <= frame_n;
				layer_q  <= layer_n;
				univ_q   <= univ_n;
				psync_q  <= psync_n;
				pcount_q <= pcount_n;
			end
		end
	end

endmodule

// ===== hw/rtl/e131pc_queue.sv =====
// ----------------------------------------------------------------------------
// e131pc_queue
// Short FIFO of classified results between parser and output stage.
// ----------------------------------------------------------------------------
module e131pc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  e131pc_pkg::result_t  push_data,
	input  logic                 pop,
	output e131pc_pkg::result_t  head,
	output logic                 empty,
	output logic                 full
);

	e131pc_pkg::result_t mem_q [e131pc_pkg::Q_DEPTH];
	logic [e131pc_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [e131pc_pkg::Q_CNT_W-1:0] count_q;

	assign empty = count_q == '0;
	assign full  = count_q == e131pc_pkg::Q_CNT_W'(e131pc_pkg::Q_DEPTH);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= e131pc_pkg::Q_CNT_W'(e131pc_pkg::Q_DEPTH))
		else $error("queue count out of range");
`endif

endmodule

// ===== hw/rtl/e131pc_back.sv =====
// ----------------------------------------------------------------------------
// e131pc_back
// Output stage: broadcast filter, sync universe store and sync request.
// ----------------------------------------------------------------------------
module e131pc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	input  e131pc_pkg::result_t  head,
	input  logic                 empty,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 slot_valid,
	output logic [8:0]           slot_number,
	output logic [7:0]           slot_data,
	output logic [15:0]          target_universe,
	output logic                 verdict_valid,
	output logic [1:0]           packet_kind,
	output logic                 accepted,
	output logic                 fire_sync
);

	logic        bcast_accept_q;
	logic [15:0] stored_sync_q;
	logic        out_valid_q;
	e131pc_pkg::result_t res_q;
	logic        acc_q, fire_q;

	logic acc, fire, store;

	assign pop = !empty && (!out_valid_q || !out_stall);

	always_comb begin
		acc   = 1'b0;
		fire  = 1'b0;
		store = 1'b0;
		case (head.kind)
			e131pc_pkg::KIND_DISCOVERY: begin
				acc = 1'b1;
			end
			e131pc_pkg::KIND_DATA: begin
				if (!(head.bcast && !bcast_accept_q)) begin
					acc   = 1'b1;
					store = 1'b1;
					fire  = head.sync_universe == 16'd0;
				end
			end
			e131pc_pkg::KIND_SYNC: begin
				if (!(head.bcast && !bcast_accept_q)) begin
					acc  = 1'b1;
					fire = head.sync_universe == stored_sync_q;
				end
			end
			default: begin
				acc = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcast_accept_q <= 1'b1;
			stored_sync_q  <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en)
				bcast_accept_q <= cfg_wr_data;
			if (pop && store)
				stored_sync_q <= head.sync_universe;
			if (pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q  <= head;
			acc_q  <= acc;
			fire_q <= fire;
		end
	end

	assign out_valid       = out_valid_q;
	assign slot_valid      = res_q.slot_valid;
	assign slot_number     = res_q.slot_number;
	assign slot_data       = res_q.slot_data;
	assign target_universe = res_q.target_universe;
	assign verdict_valid   = res_q.verdict_valid;
	assign packet_kind     = res_q.kind;
	assign accepted        = acc_q;
	assign fire_sync       = fire_q;

`ifndef SYNTHESIS
	a_fire_needs_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fire_q |-> acc_q && res_q.verdict_valid)
		else $error("sync fired on a packet not accepted");

	a_acc_needs_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && acc_q |-> res_q.kind != e131pc_pkg::KIND_INVALID)
		else $error("invalid packet accepted");

	a_store_on_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !store |=> $stable(stored_sync_q))
		else $error("sync universe changed without an accepted data packet");
`endif

endmodule

// ===== hw/rtl/e131_packet_classifier_unit.sv =====
// Each result is written into the result queue and then registered at the output; out_stall can hold it in the queue.
// Throughput: one payload byte per cycle, sustained while the output is not stalled.
// A four-entry result queue lets the parser run on while the output stage is stalled.
// Reset (arst_n low) clears parser state, the queue and the stored sync universe,
// and sets broadcast_accept to 1. No clearing pass follows reset.
// ----------------------------------------------------------------------------
// e131_packet_classifier_unit
// E1.31 receive classifier: header parser, result queue and output stage.
// ----------------------------------------------------------------------------
module e131_packet_classifier_unit #(
	parameter int MAX_PACKET_BYTES = e131pc_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  payload_byte,
	input  logic        end_of_packet,
	input  logic        via_broadcast,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        slot_valid,
	output logic [8:0]  slot_number,
	output logic [7:0]  slot_data,
	output logic [15:0] target_universe,
	output logic        verdict_valid,
	output logic [1:0]  packet_kind,
	output logic        accepted,
	output logic        fire_sync
);

	logic                take;
	logic                push, pop, empty, full;
	e131pc_pkg::result_t push_data, head;

	assign in_stall = full;
	assign take     = in_valid && !full;

	e131pc_front #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.payload_byte  (payload_byte),
		.end_of_packet (end_of_packet),
		.via_broadcast (via_broadcast),
		.push          (push),
		.push_data     (push_data)
	);

	e131pc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	e131pc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.head            (head),
		.empty           (empty),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.slot_valid      (slot_valid),
		.slot_number     (slot_number),
		.slot_data       (slot_data),
		.target_universe (target_universe),
		.verdict_valid   (verdict_valid),
		.packet_kind     (packet_kind),
		.accepted        (accepted),
		.fire_sync       (fire_sync)
	);

endmodule
